@@ rtl/dpc_pkg.sv @@
`default_nettype none
package dpc_pkg;

  // register indexes, taken from paddr[2]
  localparam logic REG_CONTACT = 1'b0;

  localparam logic [31:0] CONTACT_RESET = 32'd7680;

endpackage
`default_nettype wire

@@ rtl/dpc_front.sv @@
`default_nettype none
module dpc_front #(
  parameter int PB = 20,
  parameter int VB = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic signed [PB-1:0]       p1x,
  input  wire logic signed [PB-1:0]       p1y,
  input  wire logic signed [VB-1:0]       v1x,
  input  wire logic signed [VB-1:0]       v1y,
  input  wire logic signed [PB-1:0]       p2x,
  input  wire logic signed [PB-1:0]       p2y,
  input  wire logic signed [VB-1:0]       v2x,
  input  wire logic signed [VB-1:0]       v2y,
  input  wire logic        [PB-2:0]       contact,
  output logic                            out_valid,
  output logic [2*(PB-1)+VB:0]            nx,
  output logic [2*(PB-1)+VB:0]            ny,
  output logic [2*(PB-1)-1:0]             den,
  output logic [4*VB+2:0]                 side
);

  localparam int DW   = PB + 1;
  localparam int CB   = PB - 1;
  localparam int SQW  = 2 * DW + 1;
  localparam int CSQW = 2 * CB;
  localparam int PW   = VB + PB + 2;
  localparam int DOTW = PW + 1;
  localparam int NW   = 2 * CB + VB + 1;
  localparam int DENW = 2 * CB;

  // stage 1: differences
  logic                   s1_valid;
  logic signed [DW-1:0]   s1_dx, s1_dy;
  logic signed [VB:0]     s1_dvx, s1_dvy;
  logic [4*VB-1:0]        s1_vel;

  // stage 2: products
  logic                   s2_valid;
  logic signed [2*DW-1:0] s2_sqx, s2_sqy;
  logic signed [PW-1:0]   s2_pdx, s2_pdy;
  logic [CSQW-1:0]        s2_csq;
  logic signed [DW-1:0]   s2_dx, s2_dy;
  logic [4*VB-1:0]        s2_vel;

  // stage 3: sums and contact test
  logic                   s3_valid;
  logic [SQW-1:0]         s3_dsq;
  logic signed [DOTW-1:0] s3_dot;
  logic                   s3_hit;
  logic signed [DW-1:0]   s3_dx, s3_dy;
  logic [4*VB-1:0]        s3_vel;

  // stage 4: magnitudes and signs
  logic                   s4_valid;
  logic [DOTW-1:0]        s4_dmag;
  logic [CB-1:0]          s4_ax, s4_ay;
  logic [DENW-1:0]        s4_den;
  logic [4*VB+2:0]        s4_side;

  logic [SQW-1:0]         dsq_sum;
  logic [DOTW-1:0]        dot_abs;
  logic [DW-1:0]          dx_abs, dy_abs;
  logic [DOTW+CB-1:0]     prod_x, prod_y;

  assign dsq_sum = SQW'($unsigned(s2_sqx)) + SQW'($unsigned(s2_sqy));
  assign dot_abs = s3_dot[DOTW-1] ? $unsigned(-s3_dot) : $unsigned(s3_dot);
  assign dx_abs  = s3_dx[DW-1] ? $unsigned(-s3_dx) : $unsigned(s3_dx);
  assign dy_abs  = s3_dy[DW-1] ? $unsigned(-s3_dy) : $unsigned(s3_dy);
  assign prod_x  = s4_dmag * s4_ax;
  assign prod_y  = s4_dmag * s4_ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_dx  <= DW'(p2x) - DW'(p1x);
    s1_dy  <= DW'(p2y) - DW'(p1y);
    s1_dvx <= (VB+1)'(v2x) - (VB+1)'(v1x);
    s1_dvy <= (VB+1)'(v2y) - (VB+1)'(v1y);
    s1_vel <= {v1x, v1y, v2x, v2y};

    s2_sqx <= s1_dx * s1_dx;
    s2_sqy <= s1_dy * s1_dy;
    s2_pdx <= PW'(s1_dvx) * PW'(s1_dx);
    s2_pdy <= PW'(s1_dvy) * PW'(s1_dy);
    s2_csq <= contact * contact;
    s2_dx  <= s1_dx;
    s2_dy  <= s1_dy;
    s2_vel <= s1_vel;

    s3_dsq <= dsq_sum;
    s3_dot <= DOTW'(s2_pdx) + DOTW'(s2_pdy);
    s3_hit <= (dsq_sum != '0) && (dsq_sum < SQW'(s2_csq));
    s3_dx  <= s2_dx;
    s3_dy  <= s2_dy;
    s3_vel <= s2_vel;

    // on contact |d| is below 2^CB, so the narrow fields are exact there
    s4_dmag <= dot_abs;
    s4_ax   <= dx_abs[CB-1:0];
    s4_ay   <= dy_abs[CB-1:0];
    s4_den  <= s3_dsq[DENW-1:0];
    s4_side <= {s3_vel, s3_hit, s3_dot[DOTW-1] ^ s3_dx[DW-1],
                s3_dot[DOTW-1] ^ s3_dy[DW-1]};

    // quotient stays below 2^(VB+1) on contact (at most ~1.21 |dv|),
    // so n fits in NW bits
    nx   <= prod_x[NW-1:0];
    ny   <= prod_y[NW-1:0];
    den  <= s4_den;
    side <= s4_side;
  end

endmodule
`default_nettype wire

@@ rtl/dpc_div.sv @@
`default_nettype none
module dpc_div #(
  parameter int VB   = 16,
  parameter int NW   = 55,
  parameter int DENW = 38,
  parameter int SW   = 67
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [NW-1:0]   nx,
  input  wire logic [NW-1:0]   ny,
  input  wire logic [DENW-1:0] den,
  input  wire logic [SW-1:0]   side,
  output logic                 out_valid,
  output logic [VB:0]          qx,
  output logic [VB:0]          qy,
  output logic [DENW-1:0]      rx,
  output logic [DENW-1:0]      ry,
  output logic [DENW-1:0]      den_out,
  output logic [SW-1:0]        side_out
);

  // the correction can exceed the velocity range, so one extra quotient bit
  localparam int QB = VB + 1;

  // one quotient bit per stage, most significant first
  logic            vld [QB+1];
  logic [NW-1:0]   rem_x [QB+1];
  logic [NW-1:0]   rem_y [QB+1];
  logic [QB-1:0]   quo_x [QB+1];
  logic [QB-1:0]   quo_y [QB+1];
  logic [DENW-1:0] dd [QB+1];
  logic [SW-1:0]   sd [QB+1];

  assign vld[0]   = in_valid;
  assign rem_x[0] = nx;
  assign rem_y[0] = ny;
  assign quo_x[0] = '0;
  assign quo_y[0] = '0;
  assign dd[0]    = den;
  assign sd[0]    = side;

  for (genvar s = 0; s < QB; s++) begin : g_step
    localparam int B = QB - 1 - s;
    logic [NW-1:0] sub;
    logic          gex, gey;

    assign sub = NW'(dd[s]) << B;
    assign gex = rem_x[s] >= sub;
    assign gey = rem_y[s] >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      rem_x[s+1] <= gex ? rem_x[s] - sub : rem_x[s];
      rem_y[s+1] <= gey ? rem_y[s] - sub : rem_y[s];
      quo_x[s+1] <= quo_x[s] | (QB'(gex) << B);
      quo_y[s+1] <= quo_y[s] | (QB'(gey) << B);
      dd[s+1]    <= dd[s];
      sd[s+1]    <= sd[s];
    end
  end

  assign out_valid = vld[QB];
  assign qx        = quo_x[QB];
  assign qy        = quo_y[QB];
  assign rx        = rem_x[QB][DENW-1:0];
  assign ry        = rem_y[QB][DENW-1:0];
  assign den_out   = dd[QB];
  assign side_out  = sd[QB];

endmodule
`default_nettype wire

@@ rtl/dpc_back.sv @@
`default_nettype none
module dpc_back #(
  parameter int VB   = 16,
  parameter int DENW = 38
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [VB:0]       qx,
  input  wire logic [VB:0]       qy,
  input  wire logic [DENW-1:0]   rx,
  input  wire logic [DENW-1:0]   ry,
  input  wire logic [DENW-1:0]   den,
  input  wire logic [4*VB+2:0]   side,
  output logic                   done,
  output logic [VB-1:0]          r1x,
  output logic [VB-1:0]          r1y,
  output logic [VB-1:0]          r2x,
  output logic [VB-1:0]          r2y,
  output logic                   hit,
  output logic                   clipped
);

  localparam int XW = VB + 2;

  logic signed [VB-1:0] v1x, v1y, v2x, v2y;
  logic                 hit_in, neg_x, neg_y;
  logic [VB:0]          qfx, qfy;
  logic signed [XW-1:0] cx, cy;
  logic signed [XW-1:0] a1x, a1y, a2x, a2y;
  logic                 o1x, o1y, o2x, o2y;

  assign v1x    = $signed(side[4*VB+2 -: VB]);
  assign v1y    = $signed(side[3*VB+2 -: VB]);
  assign v2x    = $signed(side[2*VB+2 -: VB]);
  assign v2y    = $signed(side[VB+2 -: VB]);
  assign hit_in = side[2];
  assign neg_x  = side[1];
  assign neg_y  = side[0];

  // round to nearest, ties away from zero: 2r >= den
  assign qfx = qx + (VB+1)'({rx, 1'b0} >= {1'b0, den});
  assign qfy = qy + (VB+1)'({ry, 1'b0} >= {1'b0, den});
  assign cx  = neg_x ? -$signed({1'b0, qfx}) : $signed({1'b0, qfx});
  assign cy  = neg_y ? -$signed({1'b0, qfy}) : $signed({1'b0, qfy});

  assign a1x = XW'(v1x) + cx;
  assign a1y = XW'(v1y) + cy;
  assign a2x = XW'(v2x) - cx;
  assign a2y = XW'(v2y) - cy;

  function automatic logic ovf(input logic signed [XW-1:0] a);
    ovf = !((a[XW-1:VB-1] == '0) || (a[XW-1:VB-1] == '1));
  endfunction

  function automatic logic [VB-1:0] sat(input logic signed [XW-1:0] a);
    if (ovf(a)) begin
      sat = a[XW-1] ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}};
    end else begin
      sat = a[VB-1:0];
    end
  endfunction

  assign o1x = ovf(a1x);
  assign o1y = ovf(a1y);
  assign o2x = ovf(a2x);
  assign o2y = ovf(a2y);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    hit <= hit_in;
    if (hit_in) begin
      r1x     <= sat(a1x);
      r1y     <= sat(a1y);
      r2x     <= sat(a2x);
      r2y     <= sat(a2y);
      clipped <= o1x | o1y | o2x | o2y;
    end else begin
      r1x     <= v1x;
      r1y     <= v1y;
      r2x     <= v2x;
      r2y     <= v2y;
      clipped <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/disk_pair_collision_unit.sv @@
`default_nettype none
// Elastic collision of two equal-mass disks.
// Command side: a pair of disks (centres, velocities) is taken on every
// clock edge with start high; busy is always low, so a new pair may be
// issued every cycle.
// Result side: done pulses for one cycle with the new velocities, hit and
// clipped. The receiver cannot stall; each word must be taken when shown.
// The pipeline is built from 5 front stages (differences, products, sums,
// magnitudes, numerator multiply), one restoring-divide stage per quotient
// bit (VELOCITY_BITS + 1 bits) and a rounding/saturation output stage.
// Throughput is one pair per cycle.
// The contact distance lies at APB address 0; reads return it, writes are
// to be issued only while no pair is in flight.
// Reset empties the pipeline (no done pulses) and loads contact distance
// 30.0 pixels.
module disk_pair_collision_unit
  import dpc_pkg::*;
#(
  parameter int POSITION_BITS = 20,
  parameter int VELOCITY_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic signed [POSITION_BITS-1:0] first_pos_x,
  input  wire logic signed [POSITION_BITS-1:0] first_pos_y,
  input  wire logic signed [VELOCITY_BITS-1:0] first_vel_x,
  input  wire logic signed [VELOCITY_BITS-1:0] first_vel_y,
  input  wire logic signed [POSITION_BITS-1:0] second_pos_x,
  input  wire logic signed [POSITION_BITS-1:0] second_pos_y,
  input  wire logic signed [VELOCITY_BITS-1:0] second_vel_x,
  input  wire logic signed [VELOCITY_BITS-1:0] second_vel_y,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [2:0]                      paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  output logic                                 done,
  output logic signed [VELOCITY_BITS-1:0]      new_first_vel_x,
  output logic signed [VELOCITY_BITS-1:0]      new_first_vel_y,
  output logic signed [VELOCITY_BITS-1:0]      new_second_vel_x,
  output logic signed [VELOCITY_BITS-1:0]      new_second_vel_y,
  output logic                                 hit,
  output logic                                 clipped
);

  localparam int CB   = POSITION_BITS - 1;
  localparam int VB   = VELOCITY_BITS;
  localparam int NW   = 2 * CB + VB + 1;
  localparam int DENW = 2 * CB;
  localparam int SW   = 4 * VB + 3;

  logic [CB-1:0]   contact;

  logic            f_valid;
  logic [NW-1:0]   f_nx, f_ny;
  logic [DENW-1:0] f_den;
  logic [SW-1:0]   f_side;

  logic            d_valid;
  logic [VB:0]     d_qx, d_qy;
  logic [DENW-1:0] d_rx, d_ry, d_den;
  logic [SW-1:0]   d_side;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CONTACT) ? 32'(contact) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      contact <= CONTACT_RESET[CB-1:0];
    end else if (psel && penable && pwrite && (paddr[2] == REG_CONTACT)) begin
      contact <= pwdata[CB-1:0];
    end
  end

  dpc_front #(.PB(POSITION_BITS), .VB(VB)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .p1x      (first_pos_x),
    .p1y      (first_pos_y),
    .v1x      (first_vel_x),
    .v1y      (first_vel_y),
    .p2x      (second_pos_x),
    .p2y      (second_pos_y),
    .v2x      (second_vel_x),
    .v2y      (second_vel_y),
    .contact  (contact),
    .out_valid(f_valid),
    .nx       (f_nx),
    .ny       (f_ny),
    .den      (f_den),
    .side     (f_side)
  );

  dpc_div #(.VB(VB), .NW(NW), .DENW(DENW), .SW(SW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .nx       (f_nx),
    .ny       (f_ny),
    .den      (f_den),
    .side     (f_side),
    .out_valid(d_valid),
    .qx       (d_qx),
    .qy       (d_qy),
    .rx       (d_rx),
    .ry       (d_ry),
    .den_out  (d_den),
    .side_out (d_side)
  );

  dpc_back #(.VB(VB), .DENW(DENW)) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_valid),
    .qx       (d_qx),
    .qy       (d_qy),
    .rx       (d_rx),
    .ry       (d_ry),
    .den      (d_den),
    .side     (d_side),
    .done     (done),
    .r1x      (new_first_vel_x),
    .r1y      (new_first_vel_y),
    .r2x      (new_second_vel_x),
    .r2y      (new_second_vel_y),
    .hit      (hit),
    .clipped  (clipped)
  );

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import dpc_pkg::*;

  localparam int PB = 20;
  localparam int VB = 16;
  localparam int LATENCY = VB + 7;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [PB-1:0] p1x, p1y;
    logic signed [VB-1:0] v1x, v1y;
    logic signed [PB-1:0] p2x, p2y;
    logic signed [VB-1:0] v2x, v2y;
  } pair_t;

  typedef struct packed {
    logic signed [VB-1:0] n1x, n1y, n2x, n2y;
    logic hit;
    logic clipped;
  } resolved_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  pair_t drv = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready, done;
  logic signed [VB-1:0] n1x, n1y, n2x, n2y;
  logic hit, clipped;

  logic [18:0] contact_dist;
  resolved_t resolved_q[$];
  int errors = 0;
  int cycles = 0;
  int sender_idle = 0;

  always #5 clk = ~clk;

  disk_pair_collision_unit uut (
    .clk, .rst, .start, .busy,
    .first_pos_x(drv.p1x), .first_pos_y(drv.p1y),
    .first_vel_x(drv.v1x), .first_vel_y(drv.v1y),
    .second_pos_x(drv.p2x), .second_pos_y(drv.p2y),
    .second_vel_x(drv.v2x), .second_vel_y(drv.v2y),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .done,
    .new_first_vel_x(n1x), .new_first_vel_y(n1y),
    .new_second_vel_x(n2x), .new_second_vel_y(n2y),
    .hit, .clipped
  );

  task automatic report(input string what, input logic [127:0] got, input logic [127:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  // rounded, ties away from zero; sign applied after
  function automatic longint corr(input logic [63:0] dmag, input bit dneg,
                                  input longint axis, input logic [63:0] den);
    logic [63:0] n, q, r;
    bit neg;
    n = dmag * ((axis < 0) ? -axis : axis);
    q = n / den;
    r = n % den;
    neg = dneg != (axis < 0);
    if (r >= den - r) q++;
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint sat(input longint v, inout bit clip);
    if (v > 32767) begin clip = 1; return 32767; end
    if (v < -32768) begin clip = 1; return -32768; end
    return v;
  endfunction

  function automatic resolved_t resolve_pair(input pair_t p);
    longint dx, dy, qx, qy, dvx, dvy, dot;
    logic [63:0] dsq, csq, dmag;
    bit clip, dneg;
    resolved_t r;
    dx = longint'(p.p2x) - longint'(p.p1x);
    dy = longint'(p.p2y) - longint'(p.p1y);
    dsq = dx * dx + dy * dy;
    csq = contact_dist * contact_dist;
    clip = 0;
    r.n1x = p.v1x; r.n1y = p.v1y; r.n2x = p.v2x; r.n2y = p.v2y;
    r.hit = (dsq != 0) && (dsq < csq);
    if (r.hit) begin
      dvx = longint'(p.v2x) - longint'(p.v1x);
      dvy = longint'(p.v2y) - longint'(p.v1y);
      dot = dvx * dx + dvy * dy;
      dneg = dot < 0;
      dmag = dneg ? -dot : dot;
      qx = corr(dmag, dneg, dx, dsq);
      qy = corr(dmag, dneg, dy, dsq);
      r.n1x = VB'(sat(longint'(p.v1x) + qx, clip));
      r.n1y = VB'(sat(longint'(p.v1y) + qy, clip));
      r.n2x = VB'(sat(longint'(p.v2x) - qx, clip));
      r.n2y = VB'(sat(longint'(p.v2y) - qy, clip));
    end
    r.clipped = clip;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("disk_pair_collision_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    resolved_t w;
    if (!rst && done) begin
      if (resolved_q.size() == 0) begin
        report("unexpected word", {n1x, n1y, n2x, n2y}, 0);
      end else begin
        w = resolved_q.pop_front();
        if (n1x !== w.n1x) report("new_first_vel_x", n1x, w.n1x);
        if (n1y !== w.n1y) report("new_first_vel_y", n1y, w.n1y);
        if (n2x !== w.n2x) report("new_second_vel_x", n2x, w.n2x);
        if (n2y !== w.n2y) report("new_second_vel_y", n2y, w.n2y);
        if (hit !== w.hit) report("hit", hit, w.hit);
        if (clipped !== w.clipped) report("clipped", clipped, w.clipped);
      end
    end
  end

  task automatic settle();
    while (resolved_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr[2] == REG_CONTACT) contact_dist = data[18:0];
    @(posedge clk);
  endtask

  task automatic check_reg();
    psel <= 1'b1; pwrite <= 1'b0; paddr <= '0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[18:0] !== contact_dist) report("contact_distance read", prdata, contact_dist);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  // issue one pair; optionally check against a typed-in word too
  task automatic send_pair(input pair_t p, input bit typed, input resolved_t want);
    resolved_t r;
    while (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
    r = resolve_pair(p);
    if (typed && r !== want) report("typed row", r, want);
    drv <= p;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    resolved_q.push_back(r);
  endtask

  task automatic idle_input();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic pair_t rand_pair(input int spread);
    pair_t p;
    p = $bits(pair_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(9) < 8) begin
      // near-contact geometry with random velocities
      p.p2x = PB'(p.p1x + $signed($urandom_range(2 * spread) - spread));
      p.p2y = PB'(p.p1y + $signed($urandom_range(2 * spread) - spread));
      if ($urandom_range(3) == 0) begin
        p.v1x = VB'($urandom_range(511) - 256); p.v1y = VB'($urandom_range(511) - 256);
        p.v2x = VB'($urandom_range(511) - 256); p.v2y = VB'($urandom_range(511) - 256);
      end
    end
    return p;
  endfunction

  typedef struct {
    pair_t p;
    bit typed;
    resolved_t r;
  } row_t;

  row_t rows[$];

  initial begin
    row_t row;
    pair_t p;
    int phase;
    logic [18:0] settings[4];
    contact_dist = CONTACT_RESET[18:0];
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_reg();

    // coincident centres: pass-through
    row.p = '{p1x: 100, p1y: -50, v1x: 256, v1y: -256, p2x: 100, p2y: -50,
              v2x: -1, v2y: 7};
    row.typed = 1; row.r = '{n1x: 256, n1y: -256, n2x: -1, n2y: 7, hit: 0, clipped: 0};
    rows.push_back(row);
    // far apart: pass-through
    row.p = '{p1x: -524288, p1y: -524288, v1x: -32768, v1y: 32767,
              p2x: 524287, p2y: 524287, v2x: 32767, v2y: -32768};
    row.typed = 1; row.r = '{n1x: -32768, n1y: 32767, n2x: 32767, n2y: -32768,
                             hit: 0, clipped: 0};
    rows.push_back(row);
    // touching exactly at 30.0 along x: no contact
    row.p = '{p1x: 0, p1y: 0, v1x: 256, v1y: 0, p2x: 7680, p2y: 0, v2x: -256, v2y: 0};
    row.typed = 1; row.r = '{n1x: 256, n1y: 0, n2x: -256, n2y: 0, hit: 1'b0, clipped: 0};
    rows.push_back(row);
    // head-on along x: velocities swap
    row.p = '{p1x: 0, p1y: 0, v1x: 256, v1y: 0, p2x: 7679, p2y: 0, v2x: -256, v2y: 0};
    row.typed = 1; row.r = '{n1x: -256, n1y: 0, n2x: 256, n2y: 0, hit: 1, clipped: 0};
    rows.push_back(row);
    // head-on at extreme speeds: full swap, just inside the range
    row.p = '{p1x: 0, p1y: 0, v1x: 0, v1y: -32768, p2x: 0, p2y: 1, v2x: 0, v2y: 32767};
    row.typed = 1; row.r = '{n1x: 0, n1y: 32767, n2x: 0, n2y: -32768, hit: 1, clipped: 0};
    rows.push_back(row);
    row.p = '{p1x: 0, p1y: 0, v1x: 32767, v1y: 0, p2x: 1, p2y: 0, v2x: 32767, v2y: 0};
    row.typed = 1; row.r = '{n1x: 32767, n1y: 0, n2x: 32767, n2y: 0, hit: 1, clipped: 0};
    rows.push_back(row);
    row.typed = 0;
    row.p = '{p1x: 10, p1y: 20, v1x: 300, v1y: -700, p2x: 900, p2y: 1500, v2x: -40, v2y: 9};
    rows.push_back(row);
    row.p = '{p1x: 0, p1y: 0, v1x: -32768, v1y: -32768, p2x: 3, p2y: -5,
              v2x: 32767, v2y: 32767};
    rows.push_back(row);
    // diagonal offset with full-range dv: correction beyond the velocity range
    row.p = '{p1x: 0, p1y: 0, v1x: -32768, v1y: -32768, p2x: 1000, p2y: 414,
              v2x: 32767, v2y: 32767};
    rows.push_back(row);
    row.p = '{p1x: 524287, p1y: 524287, v1x: 1, v1y: 1, p2x: 524286, p2y: 524280,
              v2x: -3, v2y: 5};
    rows.push_back(row);
    row.p = '{p1x: -524288, p1y: 0, v1x: -1, v1y: 0, p2x: -524288 + 5000, p2y: -4000,
              v2x: 4000, v2y: -20000};
    rows.push_back(row);
    foreach (rows[i]) send_pair(rows[i].p, rows[i].typed, rows[i].r);
    idle_input();
    settle();

    settings = '{19'd0, 19'h7ffff, 19'd2560, 19'd40000};
    for (phase = 0; phase < 4; phase++) begin
      write_reg(3'd0, {$urandom} & ~32'h7ffff | settings[phase]);
      write_reg(3'd4, $urandom);  // unmapped index, ignored
      check_reg();
      sender_idle = (phase == 0) ? 20 : (phase == 1) ? 76 : 0;
      for (int i = 0; i < 310; i++) begin
        p = rand_pair(phase == 1 ? 524287 : (contact_dist == 0 ? 64 : 2 * contact_dist + 2));
        row.r = '0;
        send_pair(p, 0, row.r);
      end
      idle_input();
      settle();
    end

    if (errors == 0) begin
      $display("disk_pair_collision_unit regression: pass");
    end else begin
      $display("disk_pair_collision_unit regression: fail");
    end
    $finish;
  end

endmodule
